### hdl/ilid_pkg.sv
// Shared constants, codes and types for the indexed list block.
`timescale 1ns / 1ps

package ilid_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int POS_W = 8;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int LEN_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_POS  = 3'd3,
    OP_DELETE   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_cmd_t;

endpackage

### hdl/ilid_ctrl.sv
// Controller state machine: input capture, execute step and output valid.
`timescale 1ns / 1ps

module ilid_ctrl import ilid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ctl_cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  // The output register can take a new result when empty or being emptied.
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.execute = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.execute) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hdl/ilid_datapath.sv
// Datapath: command register, row of list cells, entry count and result register.
`timescale 1ns / 1ps

module ilid_datapath import ilid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_cmd_t                 cmd,
  input  logic [2:0]               operation,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic signed [DATA_W-1:0] read_value,
  output logic [1:0]               status,
  output logic [LEN_W-1:0]         length
);

  op_t                op_q;
  logic [POS_W-1:0]   position_q;
  logic [DATA_W-1:0]  value_q;

  logic [DATA_W-1:0]  entries   [LIST_DEPTH];
  logic [DATA_W-1:0]  cell_next [LIST_DEPTH];
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic [IDX_W-1:0]   pos_idx;
  logic [IDX_W-1:0]   ins_idx;
  logic               full;
  logic               pos_lt;
  logic               pos_le;
  logic               do_ins;
  logic               do_del;
  logic [DATA_W-1:0]  rd;
  status_t            st;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q       <= op_t'(operation);
      position_q <= position;
      value_q    <= value;
    end
  end

  assign pos_ext = CMP_W'(position_q);
  assign cnt_ext = CMP_W'(count);
  assign pos_idx = position_q[IDX_W-1:0];
  assign full    = (count == CNT_W'(LIST_DEPTH));
  assign pos_lt  = (pos_ext < cnt_ext);
  assign pos_le  = (pos_ext <= cnt_ext);

  always_comb begin
    rd      = '0;
    st      = ST_DONE;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    ins_idx = '0;
    case (op_q)
      OP_READ: begin
        if (pos_lt) begin
          rd = entries[pos_idx];
        end else begin
          rd = '1;
          st = ST_INVALID;
        end
      end
      OP_INS_HEAD: begin
        if (full) st = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_TAIL: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          ins_idx = count[IDX_W-1:0];
        end
      end
      OP_INS_POS: begin
        // The position check wins over the full check.
        if (!pos_le) begin
          st = ST_INVALID;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          ins_idx = pos_idx;
        end
      end
      OP_DELETE: begin
        if (!pos_lt) st = ST_INVALID;
        else do_del = 1'b1;
      end
      default: st = ST_INVALID;
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_ins) count_next = count + CNT_W'(1);
    else if (do_del) count_next = count - CNT_W'(1);
  end

  // Each cell picks its own value, its lower neighbor's, its upper neighbor's or the inserted value.
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) cell_next[i] = entries[i];
    if (do_ins) begin
      for (int i = 1; i < LIST_DEPTH; i++) begin
        if (IDX_W'(i) > ins_idx) cell_next[i] = entries[i-1];
      end
      cell_next[ins_idx] = value_q;
    end else if (do_del) begin
      for (int i = 0; i < LIST_DEPTH - 1; i++) begin
        if (IDX_W'(i) >= pos_idx) cell_next[i] = entries[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) entries <= cell_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      read_value <= rd;
      status     <= st;
      length     <= LEN_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LIST_DEPTH))
    else $error("entry count above list depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && do_ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not add one entry");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && do_del |=> count == $past(count) - CNT_W'(1))
    else $error("delete did not remove one entry");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && st != ST_DONE |=> count == $past(count))
    else $error("refused command changed the list length");

endmodule

### hdl/indexed_list_insert_delete.sv
// Top level of the indexed list: controller plus datapath.
// Usage:
//   The input channel (in_valid, in_stall) carries one command item made of
//   operation, position and value. The output channel (out_valid, out_stall)
//   returns one result item per command: read_value, status and length.
//   An input item is taken when in_valid is high and in_stall is low.
// Operation:
//   A command is captured in the idle state and executed in the execute
//   state, when every list cell moves at once and the result register is
//   loaded. in_stall stays high in the execute state, so the block takes no
//   new item until the last one has been executed.
// Stalls:
//   The result register holds while out_stall is high. A new item can be
//   captured while a result waits; its execute step waits for the result
//   register to free up, and in_stall stays high meanwhile.
// Reset:
//   rst is synchronous and active high. It empties the list and drops
//   out_valid; the block takes items in the first cycle after reset.
`timescale 1ns / 1ps

module indexed_list_insert_delete import ilid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               operation,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] read_value,
  output logic [1:0]               status,
  output logic [LEN_W-1:0]         length
);

  ctl_cmd_t cmd;

  ilid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ilid_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .operation  (operation),
    .position   (position),
    .value      (value),
    .read_value (read_value),
    .status     (status),
    .length     (length)
  );

endmodule
